// ===== sv/lru_pkg.sv =====
// Package with the sizes, register map and types shared by the LRU page frame tracker.
package lru_pkg;

    localparam int NUM_FRAMES      = 8;
    localparam int PAGE_WIDTH      = 32;
    localparam int FRAME_IDX_WIDTH = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int RANK_WIDTH      = FRAME_IDX_WIDTH;
    localparam int FILL_WIDTH      = $clog2(NUM_FRAMES + 1);
    localparam int CFG_WIDTH       = 4;
    localparam int COUNT_WIDTH     = 32;
    localparam int APB_ADDR_WIDTH  = 3;
    localparam int APB_DATA_WIDTH  = 32;

    localparam logic [CFG_WIDTH-1:0] FRAMES_IN_USE_RESET = CFG_WIDTH'(8);

    // Word index of each register (byte address divided by four).
    typedef enum logic [0:0]
    {
        REG_FRAMES_IN_USE = 1'b0
    } reg_index_t;

    typedef logic [PAGE_WIDTH-1:0]      page_t;
    typedef logic [RANK_WIDTH-1:0]      rank_t;
    typedef logic [FRAME_IDX_WIDTH-1:0] frame_idx_t;
    typedef logic [FILL_WIDTH-1:0]      fill_t;
    typedef logic [COUNT_WIDTH-1:0]     count_t;

endpackage

// ===== sv/lru_page_replacement.sv =====
// Fully associative LRU page frame tracker with an APB configuration port.
// Each word on the input channel names one page; the block answers with one result word
// that tells whether the page was resident, the saturating fault count, and the evicted
// page if there was one. A word sits in an input register while the
// tag compare against all frames, the victim search and the rank update are done in one
// pass; the result is then held in an output register. One word is taken every cycle and
// its result goes on from the input register to the output register, so the rate is one
// word per cycle as long as the output side keeps taking results; the one-pass compare
// and rank update across all frames sets that figure. Writing frames_in_use (byte address 0)
// empties every frame and clears the fault count; it must only be written while idle.
module lru_page_replacement
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lru_pkg::PAGE_WIDTH-1:0]    page_number,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lru_pkg::PAGE_WIDTH-1:0]    page_echo,
    output logic                              hit,
    output logic [lru_pkg::COUNT_WIDTH-1:0]   fault_count,
    output logic                              victim_valid,
    output logic [lru_pkg::PAGE_WIDTH-1:0]    victim_page,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lru_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [lru_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [lru_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                              pready
);
    import lru_pkg::*;

    // Configuration
    logic [CFG_WIDTH-1:0] frames_in_use_reg;
    logic                 cfg_write;
    reg_index_t           cfg_index;

    // Input stage
    logic  in_valid_reg;
    page_t in_page_reg;

    // Frame state
    page_t  frame_page_reg  [NUM_FRAMES];
    logic   [NUM_FRAMES-1:0] frame_valid_reg;
    rank_t  recency_rank_reg [NUM_FRAMES];
    fill_t  frames_filled_reg;
    count_t faults_seen_reg;

    page_t  frame_page_next  [NUM_FRAMES];
    logic   [NUM_FRAMES-1:0] frame_valid_next;
    rank_t  recency_rank_next [NUM_FRAMES];
    fill_t  frames_filled_next;
    count_t faults_seen_next;

    // Output stage
    logic   out_valid_reg;
    page_t  page_echo_reg;
    logic   hit_reg;
    count_t fault_count_reg;
    logic   victim_valid_reg;
    page_t  victim_page_reg;

    // Datapath
    logic       advance;
    logic       process;
    fill_t      capacity;
    logic       hit_c;
    frame_idx_t hit_idx;
    logic       found_c;
    frame_idx_t lru_idx;
    rank_t      best_rank;
    logic       fill_c;
    frame_idx_t target_idx;
    rank_t      target_rank;
    logic       victim_valid_c;
    page_t      victim_page_c;

    assign cfg_index = reg_index_t'(paddr[APB_ADDR_WIDTH-1:2]);
    assign cfg_write = psel && penable && pwrite && pready
                       && (cfg_index == REG_FRAMES_IN_USE);
    assign pready    = 1'b1;
    assign prdata    = (cfg_index == REG_FRAMES_IN_USE)
                       ? APB_DATA_WIDTH'(frames_in_use_reg) : '0;

    assign advance  = !out_valid_reg || out_ready;
    assign process  = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            capacity = FILL_WIDTH'(1);
        end
        else if (int'(frames_in_use_reg) > NUM_FRAMES)
        begin
            capacity = FILL_WIDTH'(NUM_FRAMES);
        end
        else
        begin
            capacity = FILL_WIDTH'(frames_in_use_reg);
        end
    end

    // Tag compare and search for the oldest valid frame.
    always_comb
    begin
        hit_c     = 1'b0;
        hit_idx   = '0;
        found_c   = 1'b0;
        lru_idx   = '0;
        best_rank = '0;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            if (!hit_c && frame_valid_reg[i] && (frame_page_reg[i] == in_page_reg))
            begin
                hit_c   = 1'b1;
                hit_idx = FRAME_IDX_WIDTH'(i);
            end
            if (frame_valid_reg[i] && (!found_c || (recency_rank_reg[i] > best_rank)))
            begin
                found_c   = 1'b1;
                best_rank = recency_rank_reg[i];
                lru_idx   = FRAME_IDX_WIDTH'(i);
            end
        end
    end

    always_comb
    begin
        fill_c = !hit_c && (frames_filled_reg < capacity);
        if (hit_c)
        begin
            target_idx = hit_idx;
        end
        else if (fill_c)
        begin
            target_idx = FRAME_IDX_WIDTH'(frames_filled_reg);
        end
        else if (found_c)
        begin
            target_idx = lru_idx;
        end
        else
        begin
            target_idx = '0;
        end
        target_rank    = recency_rank_reg[target_idx];
        victim_valid_c = !hit_c && !fill_c && found_c;
        victim_page_c  = victim_valid_c ? frame_page_reg[lru_idx] : '0;
    end

    // Next frame state: the referenced frame becomes newest and younger frames age by one.
    always_comb
    begin
        frames_filled_next = frames_filled_reg;
        faults_seen_next   = faults_seen_reg;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            frame_page_next[i]   = frame_page_reg[i];
            frame_valid_next[i]  = frame_valid_reg[i];
            recency_rank_next[i] = recency_rank_reg[i];
            if (FRAME_IDX_WIDTH'(i) == target_idx)
            begin
                recency_rank_next[i] = '0;
                if (!hit_c)
                begin
                    frame_page_next[i]  = in_page_reg;
                    frame_valid_next[i] = 1'b1;
                end
            end
            else if (frame_valid_reg[i]
                     && (!hit_c || (recency_rank_reg[i] < target_rank)))
            begin
                recency_rank_next[i] = recency_rank_reg[i] + RANK_WIDTH'(1);
            end
        end
        if (!hit_c)
        begin
            if (faults_seen_reg != '1)
            begin
                faults_seen_next = faults_seen_reg + COUNT_WIDTH'(1);
            end
            if (fill_c)
            begin
                frames_filled_next = frames_filled_reg + FILL_WIDTH'(1);
            end
            else if (!found_c)
            begin
                frames_filled_next = FILL_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
        end
        else if (cfg_write)
        begin
            frames_in_use_reg <= pwdata[CFG_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg   <= '0;
            frames_filled_reg <= '0;
            faults_seen_reg   <= '0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                recency_rank_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            frame_valid_reg   <= '0;
            frames_filled_reg <= '0;
            faults_seen_reg   <= '0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                recency_rank_reg[i] <= '0;
            end
        end
        else if (process)
        begin
            frame_valid_reg   <= frame_valid_next;
            frames_filled_reg <= frames_filled_next;
            faults_seen_reg   <= faults_seen_next;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                recency_rank_reg[i] <= recency_rank_next[i];
            end
        end
    end

    // Page tags are only ever read behind their valid bits.
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                frame_page_reg[i] <= frame_page_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end
            if (process)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_page_reg <= page_number;
        end
        if (process)
        begin
            page_echo_reg    <= in_page_reg;
            hit_reg          <= hit_c;
            fault_count_reg  <= faults_seen_next;
            victim_valid_reg <= victim_valid_c;
            victim_page_reg  <= victim_page_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign page_echo    = page_echo_reg;
    assign hit          = hit_reg;
    assign fault_count  = fault_count_reg;
    assign victim_valid = victim_valid_reg;
    assign victim_page  = victim_page_reg;

    // The number of valid frames always matches the fill count.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(frame_valid_reg) == int'(frames_filled_reg))
    else $error("valid frame count differs from fill count");

    // Frames are never filled beyond the configured capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        frames_filled_reg <= capacity)
    else $error("more frames filled than the capacity allows");

    // A hit leaves the fault counter untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && hit_c && !cfg_write) |=> $stable(faults_seen_reg))
    else $error("fault counter moved on a hit");

    // An eviction is only reported for a fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && victim_valid_reg))
    else $error("victim reported on a hit");

    // A waiting word is not overwritten while the result register is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
    else $error("input taken while the result register is stalled");

endmodule
